// ===== src/rrpg_pkg.sv =====
// shared constants, types and state codes of the round robin pairing generator
package rrpg_pkg;

    localparam int MAX_PORTS  = 32;
    localparam int PORT_BITS  = 16;
    localparam int IDX_W      = $clog2(MAX_PORTS);
    localparam int CNT_W      = 6;
    localparam int PAIR_CAP   = (MAX_PORTS + 1) / 2;
    localparam int PAIR_CNT_W = $clog2(PAIR_CAP + 1);
    localparam int SLICE_W    = 32;
    localparam int DIV_CNT_W  = $clog2(SLICE_W + 1);
    localparam int RND_W      = $clog2(MAX_PORTS);

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [CNT_W-1:0] PORT_COUNT_RESET = CNT_W'(4);
    localparam logic [CNT_W-1:0] PORT_COUNT_MIN   = CNT_W'(2);
    localparam logic [CNT_W-1:0] PORT_COUNT_MAX   = CNT_W'(MAX_PORTS);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_GEN  = 1'b1;

    localparam logic REG_PORT_COUNT = 1'b0;

    typedef struct packed {
        logic [PORT_BITS-1:0] lo;
        logic [PORT_BITS-1:0] hi;
    } pair_t;

    typedef struct packed {
        logic load_wr;
        logic gen_start;
        logic div_run;
        logic pair_init;
        logic pair_issue;
        logic emit_pop;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic issue_last;
        logic pipe_empty;
        logic cnt_zero;
        logic cnt_one;
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DIVIDE = 5'b00010,
        ST_PAIRS  = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

endpackage

// ===== src/rrpg_cmd_if.sv =====
// command channel carrying load and generate items
interface rrpg_cmd_if
    import rrpg_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [4:0]           entry_index;
    logic [PORT_BITS-1:0] port_value;
    logic [SLICE_W-1:0]   slice;

    modport source (output valid, output operation, output entry_index, output port_value,
                    output slice, input ready);
    modport sink (input valid, input operation, input entry_index, input port_value,
                  input slice, output ready);
endinterface

// ===== src/rrpg_pair_if.sv =====
// result channel carrying one port pair per item
interface rrpg_pair_if
    import rrpg_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [PORT_BITS-1:0] port_low;
    logic [PORT_BITS-1:0] port_high;
    logic                 last_pair;

    modport source (output valid, output port_low, output port_high, output last_pair,
                    input ready);
    modport sink (input valid, input port_low, input port_high, input last_pair,
                  output ready);
endinterface

// ===== src/rrpg_ctrl.sv =====
// controller state machine sequencing load, remainder, pair walk, drain and emit phases
module rrpg_ctrl
    import rrpg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  logic       cmd_op,
    input  logic       out_ready,
    input  dp_status_t status,
    output logic       cmd_ready,
    output logic       out_valid,
    output ctrl_cmd_t  ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        cmd_ready  = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    if (cmd_op == OP_GEN)
                    begin
                        ctrl.gen_start = 1'b1;
                        state_next     = ST_DIVIDE;
                    end
                    else
                    begin
                        ctrl.load_wr = 1'b1;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    ctrl.pair_init = 1'b1;
                    state_next     = ST_PAIRS;
                end
                else
                begin
                    ctrl.div_run = 1'b1;
                end
            end
            ST_PAIRS:
            begin
                ctrl.pair_issue = 1'b1;
                if (status.issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    state_next = status.cnt_zero ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    ctrl.emit_pop = 1'b1;
                    if (status.cnt_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/rrpg_dpath.sv =====
// datapath: port table, serial remainder unit, index walk and sorted pair buffer
module rrpg_dpath
    import rrpg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            ctrl,
    input  logic [CNT_W-1:0]     port_count,
    input  logic [IDX_W-1:0]     entry_index,
    input  logic [PORT_BITS-1:0] port_value,
    input  logic [SLICE_W-1:0]   slice,
    output dp_status_t           status,
    output logic [PORT_BITS-1:0] port_low,
    output logic [PORT_BITS-1:0] port_high,
    output logic                 last_pair
);

    logic [PORT_BITS-1:0]  table_mem [MAX_PORTS];

    logic [CNT_W-1:0]      real_reg;
    logic [RND_W-1:0]      rounds_reg;
    logic [PAIR_CNT_W-1:0] npairs_reg;
    logic [SLICE_W-1:0]    quo_reg;
    logic [RND_W-1:0]      rem_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [PAIR_CNT_W-1:0] k_reg;
    logic [RND_W-1:0]      fa_reg;
    logic [RND_W-1:0]      fb_reg;
    logic [PORT_BITS-1:0]  rd_a_reg;
    logic [PORT_BITS-1:0]  rd_b_reg;
    logic                  v1_reg;
    logic                  v2_reg;
    pair_t                 ins_reg;
    pair_t                 sorted_reg [PAIR_CAP];
    pair_t                 sorted_next [PAIR_CAP];
    logic [PAIR_CNT_W-1:0] cnt_reg;

    logic [CNT_W-1:0]      real_c;
    logic [CNT_W-1:0]      n_c;
    logic [RND_W:0]        trial;
    logic [RND_W-1:0]      rem_step;
    logic [RND_W-1:0]      rem_inc;
    logic [RND_W-1:0]      fa_adv;
    logic [RND_W-1:0]      fb_adv;
    logic [IDX_W-1:0]      ia;
    logic [IDX_W-1:0]      ib;
    logic                  dummy;
    logic [PAIR_CAP-1:0]   gt;

    // effective port count and round geometry
    always_comb
    begin
        if (port_count < PORT_COUNT_MIN)
        begin
            real_c = PORT_COUNT_MIN;
        end
        else if (port_count > PORT_COUNT_MAX)
        begin
            real_c = PORT_COUNT_MAX;
        end
        else
        begin
            real_c = port_count;
        end
        n_c = real_c + CNT_W'(real_c[0]);
    end

    // one remainder bit per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[SLICE_W-1]};
        if (trial >= {1'b0, rounds_reg})
        begin
            rem_step = RND_W'(trial - {1'b0, rounds_reg});
        end
        else
        begin
            rem_step = trial[RND_W-1:0];
        end
    end

    // circle positions walk forward and backward around the rounds
    always_comb
    begin
        rem_inc = rem_reg + RND_W'(1);
        fa_adv  = (fa_reg + RND_W'(1) == rounds_reg) ? '0 : fa_reg + RND_W'(1);
        fb_adv  = (fb_reg == '0) ? rounds_reg - RND_W'(1) : fb_reg - RND_W'(1);
        if (k_reg == '0)
        begin
            ia = '0;
            ib = IDX_W'(rem_inc);
        end
        else
        begin
            ia = IDX_W'(fa_reg + RND_W'(1));
            ib = IDX_W'(fb_reg + RND_W'(1));
        end
        dummy = ({1'b0, ia} >= real_reg) || ({1'b0, ib} >= real_reg);
    end

    // sorted insertion, entries past the fill count act as larger than any pair
    always_comb
    begin
        for (int i = 0; i < PAIR_CAP; i++)
        begin
            gt[i] = (PAIR_CNT_W'(i) >= cnt_reg) || (sorted_reg[i] > ins_reg);
        end
        for (int i = 0; i < PAIR_CAP; i++)
        begin
            sorted_next[i] = sorted_reg[i];
        end
        if (v2_reg)
        begin
            if (gt[0])
            begin
                sorted_next[0] = ins_reg;
            end
            for (int i = 1; i < PAIR_CAP; i++)
            begin
                if (gt[i])
                begin
                    sorted_next[i] = gt[i-1] ? sorted_reg[i-1] : ins_reg;
                end
            end
        end
        else if (ctrl.emit_pop)
        begin
            for (int i = 0; i < PAIR_CAP - 1; i++)
            begin
                sorted_next[i] = sorted_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_wr)
        begin
            table_mem[entry_index] <= port_value;
        end
        if (ctrl.pair_issue)
        begin
            rd_a_reg <= table_mem[ia];
            rd_b_reg <= table_mem[ib];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.gen_start)
        begin
            real_reg   <= real_c;
            rounds_reg <= RND_W'(n_c - CNT_W'(1));
            npairs_reg <= PAIR_CNT_W'(n_c[CNT_W-1:1]);
            quo_reg    <= slice;
            rem_reg    <= '0;
        end
        else if (ctrl.div_run)
        begin
            quo_reg <= {quo_reg[SLICE_W-2:0], 1'b0};
            rem_reg <= rem_step;
        end
        if (ctrl.pair_init)
        begin
            fa_reg <= (rem_inc == rounds_reg) ? '0 : rem_inc;
            fb_reg <= (rem_reg == '0) ? rounds_reg - RND_W'(1) : rem_reg - RND_W'(1);
        end
        else if (ctrl.pair_issue && k_reg != '0)
        begin
            fa_reg <= fa_adv;
            fb_reg <= fb_adv;
        end
        if (v1_reg)
        begin
            ins_reg.lo <= (rd_a_reg > rd_b_reg) ? rd_b_reg : rd_a_reg;
            ins_reg.hi <= (rd_a_reg > rd_b_reg) ? rd_a_reg : rd_b_reg;
        end
        for (int i = 0; i < PAIR_CAP; i++)
        begin
            sorted_reg[i] <= sorted_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
            k_reg       <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (ctrl.gen_start)
            begin
                div_cnt_reg <= DIV_CNT_W'(SLICE_W);
            end
            else if (ctrl.div_run)
            begin
                div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
            end
            if (ctrl.pair_init)
            begin
                k_reg <= '0;
            end
            else if (ctrl.pair_issue)
            begin
                k_reg <= k_reg + PAIR_CNT_W'(1);
            end
            v1_reg <= ctrl.pair_issue && !dummy;
            v2_reg <= v1_reg;
            if (ctrl.gen_start)
            begin
                cnt_reg <= '0;
            end
            else if (v2_reg)
            begin
                cnt_reg <= cnt_reg + PAIR_CNT_W'(1);
            end
            else if (ctrl.emit_pop)
            begin
                cnt_reg <= cnt_reg - PAIR_CNT_W'(1);
            end
        end
    end

    assign status.div_done   = (div_cnt_reg == '0);
    assign status.issue_last = (k_reg == npairs_reg - PAIR_CNT_W'(1));
    assign status.pipe_empty = !v1_reg && !v2_reg;
    assign status.cnt_zero   = (cnt_reg == '0);
    assign status.cnt_one    = (cnt_reg == PAIR_CNT_W'(1));

    assign port_low  = sorted_reg[0].lo;
    assign port_high = sorted_reg[0].hi;
    assign last_pair = status.cnt_one;

endmodule

// ===== src/round_robin_pairing_generator_core.sv =====
// Round robin pairing generator, top level with the configuration port.
// A load item writes one port table entry. A generate item reduces its slice
// modulo the round count in a bit-serial remainder unit, walks the circle
// positions one pair per cycle through a two-port table read and a sorted
// insertion buffer, drains the pipeline, then offers its pairs in ascending
// order one per cycle while the result side accepts them, the last one flagged.
// No new item is taken until every pair of the current slice has been
// delivered. port_count is set over APB at byte address 0 and should only be
// written while the block is idle.
module round_robin_pairing_generator_core
    import rrpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    rrpg_cmd_if.sink              cmd,
    rrpg_pair_if.source           pair
);

    logic [CNT_W-1:0] port_count_reg;
    logic             cfg_idx;
    logic             cfg_wr;
    ctrl_cmd_t        ctrl;
    dp_status_t       status;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_ADDR_W-1];
    assign cfg_wr  = psel && penable && pwrite && (cfg_idx == REG_PORT_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_count_reg <= PORT_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            port_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_PORT_COUNT: prdata = APB_DATA_W'(port_count_reg);
            default:        prdata = '0;
        endcase
    end

    rrpg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_op    (cmd.operation),
        .out_ready (pair.ready),
        .status    (status),
        .cmd_ready (cmd.ready),
        .out_valid (pair.valid),
        .ctrl      (ctrl)
    );

    rrpg_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .port_count  (port_count_reg),
        .entry_index (cmd.entry_index),
        .port_value  (cmd.port_value),
        .slice       (cmd.slice),
        .status      (status),
        .port_low    (pair.port_low),
        .port_high   (pair.port_high),
        .last_pair   (pair.last_pair)
    );

    // results and new items never overlap
    assert property (@(posedge clk) disable iff (!rst_n) !(pair.valid && cmd.ready))
        else $error("result offered while taking items");

    // a generate item always leads to a busy block
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && cmd.operation == OP_GEN) |=> !cmd.ready)
        else $error("generate item did not start work");

    // delivering the flagged pair frees the block
    assert property (@(posedge clk) disable iff (!rst_n)
        (pair.valid && pair.ready && pair.last_pair) |=> (cmd.ready && !pair.valid))
        else $error("block not idle after last pair");

    // a pair stream never ends on an unflagged pair
    assert property (@(posedge clk) disable iff (!rst_n)
        (pair.valid && pair.ready && !pair.last_pair) |=> pair.valid)
        else $error("pair stream ended without last pair");

endmodule
